FILE: sv/ssp_pkg.sv
// Package with shared types, constants and the CRC byte update for the SSP deframer.
package ssp_pkg;

  localparam logic [7:0]  DELIM_RESET   = 8'hC0;
  localparam logic [7:0]  ESCAPE_RESET  = 8'hDB;
  localparam logic [7:0]  MAX_RESET     = 8'd234;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          APB_ADDR_W    = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_DELIM  = 2'd0;
  localparam logic [1:0] REG_ESCAPE = 2'd1;
  localparam logic [1:0] REG_MAX    = 2'd2;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERROR = 3'd2,
    KIND_SHORT     = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] delimiter_byte;
    logic [7:0] escape_byte;
    logic [7:0] max_frame_bytes;
  } cfg_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/ssp_cfg.sv
// APB configuration registers of the SSP deframer.
module ssp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ssp_pkg::cfg_t                    cfg
);
  import ssp_pkg::*;

  logic [1:0] reg_index;
  logic       write_en;

  assign reg_index = paddr[3:2];
  assign write_en  = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes on the access cycle of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_byte  <= DELIM_RESET;
      cfg.escape_byte     <= ESCAPE_RESET;
      cfg.max_frame_bytes <= MAX_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_DELIM:  cfg.delimiter_byte  <= pwdata[7:0];
        REG_ESCAPE: cfg.escape_byte     <= pwdata[7:0];
        REG_MAX:    cfg.max_frame_bytes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data; unused addresses read as zero.
  always_comb begin
    unique case (reg_index)
      REG_DELIM:  prdata = {24'd0, cfg.delimiter_byte};
      REG_ESCAPE: prdata = {24'd0, cfg.escape_byte};
      REG_MAX:    prdata = {24'd0, cfg.max_frame_bytes};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/ssp_core.sv
// Deframing, unstuffing, two-byte hold and CRC check between an input and a result register.
module ssp_core (
  input  logic            clk,
  input  logic            rst,
  input  ssp_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output ssp_pkg::kind_t  out_kind,
  output logic [7:0]      out_byte,
  output logic            out_end,
  output logic [7:0]      out_index
);
  import ssp_pkg::*;

  // Input register.
  logic       stage_valid;
  logic [7:0] stage_byte;

  // Frame state.
  logic        inside_frame, inside_frame_next;
  logic        escape_pending, escape_pending_next;
  logic [15:0] crc_register, crc_register_next;
  logic [7:0]  hold_older, hold_older_next;
  logic [7:0]  hold_newer, hold_newer_next;
  logic [1:0]  held_count, held_count_next;
  logic [7:0]  frame_byte_count, frame_byte_count_next;
  logic        overflowed, overflowed_next;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_end;
  logic [7:0]  res_index;
  logic        is_data;
  logic        advance;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && out_free;
  assign in_ready = !stage_valid || advance;

  // Input register: refilled when empty or whenever the held byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
    end
  end

  // Decision for the byte in the input register.
  always_comb begin
    inside_frame_next     = inside_frame;
    escape_pending_next   = escape_pending;
    crc_register_next     = crc_register;
    hold_older_next       = hold_older;
    hold_newer_next       = hold_newer;
    held_count_next       = held_count;
    frame_byte_count_next = frame_byte_count;
    overflowed_next       = overflowed;
    res_valid             = 1'b0;
    res_kind              = KIND_PAYLOAD;
    res_byte              = 8'd0;
    res_end               = 1'b0;
    res_index             = 8'd0;
    is_data               = 1'b0;

    priority if (!inside_frame) begin
      if (stage_byte == cfg.delimiter_byte) begin
        inside_frame_next     = 1'b1;
        escape_pending_next   = 1'b0;
        crc_register_next     = CRC_INIT;
        hold_older_next       = 8'd0;
        hold_newer_next       = 8'd0;
        held_count_next       = 2'd0;
        frame_byte_count_next = 8'd0;
        overflowed_next       = 1'b0;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      is_data             = 1'b1;
    end else if (stage_byte == cfg.delimiter_byte) begin
      // Closing delimiter: one status result.
      inside_frame_next   = 1'b0;
      escape_pending_next = 1'b0;
      res_valid           = 1'b1;
      res_end             = 1'b1;
      priority if (overflowed) begin
        res_kind = KIND_OVERFLOW;
      end else if (held_count < 2'd2) begin
        res_kind = KIND_SHORT;
      end else if (crc_register[7:0] == hold_older && crc_register[15:8] == hold_newer) begin
        res_kind = KIND_GOOD;
      end else begin
        res_kind = KIND_CRC_ERROR;
      end
    end else if (stage_byte == cfg.escape_byte) begin
      escape_pending_next = 1'b1;
    end else begin
      is_data = 1'b1;
    end

    // Data byte: limit check, then the two-byte hold stage.
    if (is_data) begin
      if (frame_byte_count >= cfg.max_frame_bytes) begin
        overflowed_next = 1'b1;
      end else begin
        frame_byte_count_next = frame_byte_count + 8'd1;
        unique case (held_count)
          2'd0: begin
            hold_older_next = stage_byte;
            held_count_next = 2'd1;
          end
          2'd1: begin
            hold_newer_next = stage_byte;
            held_count_next = 2'd2;
          end
          default: begin
            hold_older_next   = hold_newer;
            hold_newer_next   = stage_byte;
            crc_register_next = crc_feed(crc_register, hold_older);
            res_valid         = 1'b1;
            res_kind          = KIND_PAYLOAD;
            res_byte          = hold_older;
            res_index         = frame_byte_count - 8'd2;
          end
        endcase
      end
    end
  end

  // Frame state advances with each byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame     <= 1'b0;
      escape_pending   <= 1'b0;
      crc_register     <= CRC_INIT;
      hold_older       <= 8'd0;
      hold_newer       <= 8'd0;
      held_count       <= 2'd0;
      frame_byte_count <= 8'd0;
      overflowed       <= 1'b0;
    end else if (advance) begin
      inside_frame     <= inside_frame_next;
      escape_pending   <= escape_pending_next;
      crc_register     <= crc_register_next;
      hold_older       <= hold_older_next;
      hold_newer       <= hold_newer_next;
      held_count       <= held_count_next;
      frame_byte_count <= frame_byte_count_next;
      overflowed       <= overflowed_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
    if (advance && res_valid) begin
      out_kind  <= res_kind;
      out_byte  <= res_byte;
      out_end   <= res_end;
      out_index <= res_index;
    end
  end

endmodule

FILE: sv/ssp_frame_deframer_crc_check.sv
// Top level of the SSP deframer with CRC-16 check.
//
//  Channel | Direction | Contents
//  s_axis  | in        | tdata[7:0] rx_byte
//  m_axis  | out       | tdata payload_byte, payload_index; tuser result_kind; tlast frame_end
//  apb     | in/out    | delimiter_byte @0x0, escape_byte @0x4, max_frame_bytes @0x8
//
// One byte is accepted every cycle unless the result register stalls; each byte is held in
// the input register, and its result, if any, is then registered in the result register.
// The byte-wide CRC update and the stuffing decision sit between those two registers.
// Reset is synchronous and active high and returns all frame state to idle.
// A stalled result register holds the input register, and s_tready falls only then.
module ssp_frame_deframer_crc_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [7:0] payload_byte, [15:8] payload_index
  output logic [2:0]                      m_tuser,   // [2:0] result_kind
  output logic                            m_tlast,   // frame_end
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ssp_pkg::*;

  cfg_t       cfg;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic [7:0] out_index;

  // Configuration registers.
  ssp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Deframing datapath.
  ssp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_end   (m_tlast),
    .out_index (out_index)
  );

  // Pack the result fields onto the stream.
  assign m_tdata = {out_index, out_byte};
  assign m_tuser = out_kind;

endmodule

FILE: dv/ssp_frame_deframer_crc_check_tb.sv
// Self-checking testbench for the SSP deframer: directed table, then random frames with a CRC.
`timescale 1ns / 1ps

module ssp_frame_deframer_crc_check_tb;
  import ssp_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int STALL_CYCLES    = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES          = 6;

  // One result as the block should present it on the master side.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] pbyte;
    logic       eof;
    logic [7:0] pindex;
  } frame_result_t;

  // Deframer state as tracked by the predictor.
  typedef struct packed {
    logic        in_frame;
    logic        escaped;
    logic [15:0] crc;
    logic [7:0]  older;
    logic [7:0]  newer;
    logic [1:0]  held;
    logic [7:0]  count;
    logic        ovf;
  } deframe_state_t;

  typedef enum logic {ROW_RX, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [1:0] reg_idx;
    logic [7:0] value;
    logic       typed;
    kind_t      kind;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [7:0]              s_tdata;   // [7:0] rx_byte
  logic                    m_tvalid;
  logic                    m_tready;
  logic [15:0]             m_tdata;   // [7:0] payload_byte, [15:8] payload_index
  logic [2:0]              m_tuser;   // [2:0] result_kind
  logic                    m_tlast;   // frame_end
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  cfg_t            cfg;
  deframe_state_t  deframe;
  frame_result_t   expected_results [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              source_idle_pct = 0;
  int              sink_idle_pct = 0;
  bit              stall_request = 1'b0;

  // Directed stimulus; status rows whose outcome is obvious carry it typed in.
  stim_row_t directed_rows [27] = '{
    '{ROW_RX,  REG_DELIM,  8'hDB, 1'b0, KIND_PAYLOAD},   // escape outside a frame
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b1, KIND_SHORT},     // empty frame
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'h11, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b1, KIND_SHORT},     // one-byte frame
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hFF, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hFF, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b1, KIND_GOOD},      // CRC of nothing is 0xFFFF
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'h00, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hDB, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},   // escaped delimiter is data
    '{ROW_RX,  REG_DELIM,  8'hDB, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hDB, 1'b0, KIND_PAYLOAD},   // escaped escape is data
    '{ROW_RX,  REG_DELIM,  8'h80, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_CFG, REG_MAX,    8'h01, 1'b0, KIND_PAYLOAD},   // limit below four
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hA1, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hA2, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'hC0, 1'b1, KIND_OVERFLOW},
    '{ROW_CFG, REG_DELIM,  8'h7E, 1'b0, KIND_PAYLOAD},   // delimiter equal to escape
    '{ROW_CFG, REG_ESCAPE, 8'h7E, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'h7E, 1'b0, KIND_PAYLOAD},
    '{ROW_RX,  REG_DELIM,  8'h7E, 1'b1, KIND_SHORT}      // delimiter wins, frame closes
  };

  ssp_frame_deframer_crc_check DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock of 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reflected CRC-16 over one byte, polynomial 0x8408.
  function automatic logic [15:0] crc16_x25_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Advances the predicted deframer by one line byte; returns 1 when a result is due.
  function automatic bit predict_rx(input logic [7:0] b, output frame_result_t r);
    logic [7:0] pos;
    r = '{kind: KIND_PAYLOAD, pbyte: 8'h00, eof: 1'b0, pindex: 8'h00};
    if (!deframe.in_frame) begin
      if (b == cfg.delimiter_byte) begin
        deframe = '0;
        deframe.in_frame = 1'b1;
        deframe.crc = CRC_INIT;
      end
      return 1'b0;
    end
    if (!deframe.escaped && b == cfg.delimiter_byte) begin
      if (deframe.ovf) r.kind = KIND_OVERFLOW;
      else if (deframe.held < 2) r.kind = KIND_SHORT;
      else if (deframe.crc[7:0] == deframe.older && deframe.crc[15:8] == deframe.newer)
        r.kind = KIND_GOOD;
      else r.kind = KIND_CRC_ERROR;
      r.eof = 1'b1;
      deframe.in_frame = 1'b0;
      deframe.escaped = 1'b0;
      return 1'b1;
    end
    if (!deframe.escaped && b == cfg.escape_byte) begin
      deframe.escaped = 1'b1;
      return 1'b0;
    end
    deframe.escaped = 1'b0;
    // Data byte: dropped beyond the limit, otherwise it pushes the two-byte hold stage.
    if (deframe.count >= cfg.max_frame_bytes) begin
      deframe.ovf = 1'b1;
      return 1'b0;
    end
    pos = deframe.count;
    deframe.count = deframe.count + 8'd1;
    if (deframe.held == 2'd0) begin
      deframe.older = b;
      deframe.held = 2'd1;
      return 1'b0;
    end
    if (deframe.held == 2'd1) begin
      deframe.newer = b;
      deframe.held = 2'd2;
      return 1'b0;
    end
    r.pbyte = deframe.older;
    r.pindex = pos - 8'd2;
    deframe.crc = crc16_x25_step(deframe.crc, deframe.older);
    deframe.older = deframe.newer;
    deframe.newer = b;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Offers one byte on the slave side after a random gap and waits for the transaction.
  task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                         input frame_result_t typed_res = '0);
    frame_result_t r;
    while ($urandom_range(99) < source_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    if (predict_rx(b, r)) expected_results.push_back(typed ? typed_res : r);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Waits until every expected result has come out and the pipeline is empty.
  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Settles the pipeline, writes one register over APB, then reads it back and checks it.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    settle_pipeline();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h000000, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_DELIM:  cfg.delimiter_byte  = v;
      REG_ESCAPE: cfg.escape_byte     = v;
      REG_MAX:    cfg.max_frame_bytes = v;
      default: ;
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== v)
      report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata[7:0], v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sends one random frame, mostly well formed, sometimes broken; returns how many line bytes it sent.
  task automatic send_frame(output int sent);
    logic [7:0]  body [$];
    logic [7:0]  pb;
    logic [15:0] crc;
    int          len, mode, room, top, k, noise;
    bit          corrupt, dangle, add_crc;
    sent    = 0;
    room    = int'(cfg.max_frame_bytes) - 2;
    top     = (room < 12) ? room : 12;
    mode    = $urandom_range(99);
    corrupt = 1'b0;
    dangle  = 1'b0;
    add_crc = 1'b1;
    if (mode < 60) len = $urandom_range(top, 0);
    else if (mode < 72) len = $urandom_range((room < 60) ? room : 60, top);
    else if (mode < 74) len = room;
    else if (mode < 82) begin
      len = $urandom_range(top, 0);
      corrupt = 1'b1;
    end else if (mode < 90) len = room + $urandom_range(3, 1);
    else if (mode < 95) begin
      len = $urandom_range(1, 0);
      add_crc = 1'b0;
    end else begin
      len = $urandom_range(top, 0);
      dangle = 1'b1;
    end

    // Payload leans on the delimiter and escape values so that stuffing is exercised.
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      pb = (k < 12) ? cfg.delimiter_byte : (k < 24) ? cfg.escape_byte : 8'($urandom);
      body.push_back(pb);
      crc = crc16_x25_step(crc, pb);
    end
    if (add_crc) begin
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    if (corrupt) begin
      k = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ 8'(1 << $urandom_range(7));
    end

    // Line noise before the frame is ignored unless it happens to hold a delimiter.
    noise = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    repeat (noise) begin
      send_rx(8'($urandom));
      sent++;
    end

    send_rx(cfg.delimiter_byte);
    sent++;
    foreach (body[i]) begin
      if (body[i] == cfg.delimiter_byte || body[i] == cfg.escape_byte) begin
        send_rx(cfg.escape_byte);
        sent++;
      end
      send_rx(body[i]);
      sent++;
    end
    // An escape just before the delimiter turns it into data; a second one closes.
    if (dangle) begin
      send_rx(cfg.escape_byte);
      send_rx(cfg.delimiter_byte);
      sent += 2;
    end
    send_rx(cfg.delimiter_byte);
    sent++;
  endtask

  // Master side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d tdata %h", m_tuser, m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", m_tuser, want.kind));
        if (m_tdata[7:0] !== want.pbyte)
          report_mismatch($sformatf("payload_byte %h, expected %h", m_tdata[7:0], want.pbyte));
        if (m_tlast !== want.eof)
          report_mismatch($sformatf("frame_end %b, expected %b", m_tlast, want.eof));
        if (m_tdata[15:8] !== want.pindex)
          report_mismatch($sformatf("payload_index %0d, expected %0d", m_tdata[15:8],
                                    want.pindex));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases under varied settings.
  initial begin
    int            n;
    int            frame_items;
    frame_result_t typed_res;
    logic [7:0]    d;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = 32'h0;
    cfg      = '{delimiter_byte: DELIM_RESET, escape_byte: ESCAPE_RESET,
                 max_frame_bytes: MAX_RESET};
    deframe  = '0;
    deframe.crc = CRC_INIT;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    source_idle_pct = 11;
    sink_idle_pct   = 48;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        typed_res = '{kind: directed_rows[i].kind, pbyte: 8'h00, eof: 1'b1, pindex: 8'h00};
        send_rx(directed_rows[i].value, directed_rows[i].typed, typed_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      source_idle_pct = (p < 2) ? 11 : (p < 4) ? 48 : 0;
      sink_idle_pct   = (p < 2) ? 48 : (p < 4) ? 11 : 0;
      case (p)
        0: begin
          write_reg(REG_DELIM, DELIM_RESET);
          write_reg(REG_ESCAPE, ESCAPE_RESET);
          write_reg(REG_MAX, MAX_RESET);
        end
        1: begin
          write_reg(REG_DELIM, 8'h00);
          write_reg(REG_ESCAPE, 8'hFF);
          write_reg(REG_MAX, 8'd4);
        end
        2: begin
          write_reg(REG_DELIM, 8'hFF);
          write_reg(REG_ESCAPE, 8'h00);
          write_reg(REG_MAX, 8'd255);
        end
        default: begin
          d = 8'($urandom);
          write_reg(REG_DELIM, d);
          write_reg(REG_ESCAPE, d ^ 8'($urandom_range(255, 1)));
          write_reg(REG_MAX, 8'($urandom_range(60, 4)));
        end
      endcase
      // The long hold-off lets the sender run into a full pipeline.
      if (p == 0) stall_request = 1'b1;
      frame_items = 0;
      while (frame_items < ITEMS_PER_PHASE) begin
        send_frame(n);
        frame_items += n;
      end
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ssp_pkg.sv
sv/ssp_cfg.sv
sv/ssp_core.sv
sv/ssp_frame_deframer_crc_check.sv
dv/ssp_frame_deframer_crc_check_tb.sv
